@@ rtl/afbu_pkg.sv @@
package afbu_pkg;

    // number format: signed q4.12 in a 16-bit word
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;

    // lookup grid: 2^SEG_BITS equal segments over [-8, 8)
    localparam int SEG_BITS  = 6;
    localparam int NSEG      = 1 << SEG_BITS;
    localparam int SEG_SHIFT = FRAC_BITS + 4 - SEG_BITS;
    localparam int IDX_W     = SEG_BITS + 1;

    // table entries reach +8.0, beyond the data word; the table word is two bits wider
    localparam int TAB_W     = DATA_W + 2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [TAB_W-1:0]  t_tab;

    // configuration register indexes
    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_DIR  = 1'b1;

    // activation kinds
    localparam logic [1:0] KIND_RELU   = 2'd0;
    localparam logic [1:0] KIND_GELU   = 2'd1;
    localparam logic [1:0] KIND_SIG    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // pass direction
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    // table selection
    localparam logic [1:0] TAB_GELU     = 2'd0;
    localparam logic [1:0] TAB_GELU_DER = 2'd1;
    localparam logic [1:0] TAB_SIG      = 2'd2;
    localparam logic [1:0] TAB_SIG_DER  = 2'd3;

    // x * phi(x) at every segment end, q.12
    localparam t_tab GELU_TAB [0:NSEG] = '{
        18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     18'sd0,     -18'sd1,    -18'sd1,
        -18'sd3,    -18'sd8,    -18'sd17,   -18'sd34,   -18'sd64,   -18'sd113,
        -18'sd186,  -18'sd287,  -18'sd410,  -18'sd541,  -18'sd650,  -18'sd696,
        -18'sd632,  -18'sd411,  18'sd0,     18'sd613,   18'sd1416,  18'sd2376,
        18'sd3446,  18'sd4579,  18'sd5734,  18'sd6881,  18'sd8006,  18'sd9103,
        18'sd10176, 18'sd11230, 18'sd12271, 18'sd13304, 18'sd14333, 18'sd15359,
        18'sd16383, 18'sd17408, 18'sd18432, 18'sd19456, 18'sd20480, 18'sd21504,
        18'sd22528, 18'sd23552, 18'sd24576, 18'sd25600, 18'sd26624, 18'sd27648,
        18'sd28672, 18'sd29696, 18'sd30720, 18'sd31744, 18'sd32768
    };

    // gelu derivative, q.12
    localparam t_tab GELU_DER_TAB [0:NSEG] = '{
        18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,     18'sd0,
        18'sd0,     18'sd0,     18'sd0,     -18'sd1,    -18'sd2,    -18'sd5,
        -18'sd12,   -18'sd25,   -18'sd49,   -18'sd90,   -18'sd154,  -18'sd242,
        -18'sd349,  -18'sd454,  -18'sd522,  -18'sd502,  -18'sd341,  18'sd3,
        18'sd543,   18'sd1248,  18'sd2048,  18'sd2848,  18'sd3553,  18'sd4093,
        18'sd4437,  18'sd4598,  18'sd4618,  18'sd4550,  18'sd4445,  18'sd4338,
        18'sd4250,  18'sd4186,  18'sd4145,  18'sd4121,  18'sd4108,  18'sd4101,
        18'sd4098,  18'sd4097,  18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096,
        18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096,
        18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096,  18'sd4096
    };

    // logistic sigmoid, q.12
    localparam t_tab SIG_TAB [0:NSEG] = '{
        18'sd1,     18'sd2,     18'sd2,     18'sd3,     18'sd4,     18'sd5,
        18'sd6,     18'sd8,     18'sd10,    18'sd13,    18'sd17,    18'sd21,
        18'sd27,    18'sd35,    18'sd45,    18'sd58,    18'sd74,    18'sd94,
        18'sd120,   18'sd153,   18'sd194,   18'sd246,   18'sd311,   18'sd391,
        18'sd488,   18'sd606,   18'sd747,   18'sd912,   18'sd1102,  18'sd1314,
        18'sd1546,  18'sd1793,  18'sd2048,  18'sd2303,  18'sd2550,  18'sd2782,
        18'sd2994,  18'sd3184,  18'sd3349,  18'sd3490,  18'sd3608,  18'sd3705,
        18'sd3785,  18'sd3850,  18'sd3902,  18'sd3943,  18'sd3976,  18'sd4002,
        18'sd4022,  18'sd4038,  18'sd4051,  18'sd4061,  18'sd4069,  18'sd4075,
        18'sd4079,  18'sd4083,  18'sd4086,  18'sd4088,  18'sd4090,  18'sd4091,
        18'sd4092,  18'sd4093,  18'sd4094,  18'sd4094,  18'sd4095
    };

    // sigmoid derivative s * (1 - s), q.12
    localparam t_tab SIG_DER_TAB [0:NSEG] = '{
        18'sd1,     18'sd2,     18'sd2,     18'sd3,     18'sd4,     18'sd5,
        18'sd6,     18'sd8,     18'sd10,    18'sd13,    18'sd17,    18'sd21,
        18'sd27,    18'sd35,    18'sd45,    18'sd57,    18'sd72,    18'sd92,
        18'sd117,   18'sd147,   18'sd185,   18'sd231,   18'sd287,   18'sd353,
        18'sd430,   18'sd517,   18'sd611,   18'sd709,   18'sd805,   18'sd892,
        18'sd963,   18'sd1008,  18'sd1024,  18'sd1008,  18'sd963,   18'sd892,
        18'sd805,   18'sd709,   18'sd611,   18'sd517,   18'sd430,   18'sd353,
        18'sd287,   18'sd231,   18'sd185,   18'sd147,   18'sd117,   18'sd92,
        18'sd72,    18'sd57,    18'sd45,    18'sd35,    18'sd27,    18'sd21,
        18'sd17,    18'sd13,    18'sd10,    18'sd8,     18'sd6,     18'sd5,
        18'sd4,     18'sd3,     18'sd2,     18'sd2,     18'sd1
    };

endpackage

@@ rtl/activation_forward_backward_unit_core.sv @@
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// input     | i_in_valid, o_in_ready, i_x_value,        | in
//           | i_grad_in                                 |
// result    | o_out_valid, i_out_ready, o_result        | out
// config    | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// one item per cycle sustained unless the output stalls; each item passes
// five register stages (table lookup, interpolation product, interpolation
// sum, gradient product, round and saturate into the output register).
// reset (synchronous, active low) empties the pipeline and sets relu forward.
// a stall at the output holds every full stage in place; the input is taken
// whenever the first stage is empty or moving on.
module activation_forward_backward_unit_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [afbu_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [afbu_pkg::DATA_W-1:0] i_grad_in,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [afbu_pkg::DATA_W-1:0] o_result,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [1:0]                       i_cfg_data
);

    localparam int DW   = afbu_pkg::DATA_W;
    localparam int FB   = afbu_pkg::FRAC_BITS;
    localparam int SH   = afbu_pkg::SEG_SHIFT;
    localparam int TW   = afbu_pkg::TAB_W;
    localparam int IW   = afbu_pkg::IDX_W;
    localparam int SB   = afbu_pkg::SEG_BITS;
    // interpolation product: (TW+1)-bit difference times SH-bit offset
    localparam int PW   = TW + 1 + SH + 1;
    // gradient product
    localparam int GW   = DW + TW;
    // rounded gradient before saturation
    localparam int RW   = GW - FB + 1;

    localparam logic signed [DW-1:0] SAT_HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO = {1'b1, {(DW-1){1'b0}}};

    // table read for the selected function
    function automatic afbu_pkg::t_tab f_lookup(input logic [1:0] sel,
                                                input logic [IW-1:0] idx);
        afbu_pkg::t_tab val;
        unique case (sel)
            afbu_pkg::TAB_GELU:     val = afbu_pkg::GELU_TAB[idx];
            afbu_pkg::TAB_GELU_DER: val = afbu_pkg::GELU_DER_TAB[idx];
            afbu_pkg::TAB_SIG:      val = afbu_pkg::SIG_TAB[idx];
            afbu_pkg::TAB_SIG_DER:  val = afbu_pkg::SIG_DER_TAB[idx];
            default:                val = '0;
        endcase
        return val;
    endfunction

    // configuration registers
    logic [1:0] r_kind;
    logic       r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= afbu_pkg::KIND_RELU;
            r_dir  <= afbu_pkg::DIR_FWD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                afbu_pkg::CFG_KIND: r_kind <= i_cfg_data;
                afbu_pkg::CFG_DIR:  r_dir  <= i_cfg_data[0];
                default:            r_kind <= r_kind;
            endcase
        end
    end

    // stage valids and advance chain
    logic r1_v, r2_v, r3_v, r4_v;
    logic w_adv1, w_adv2, w_adv3, w_adv4, w_adv5;

    assign w_adv5     = !o_out_valid || i_out_ready;
    assign w_adv4     = !r4_v || w_adv5;
    assign w_adv3     = !r3_v || w_adv4;
    assign w_adv2     = !r2_v || w_adv3;
    assign w_adv1     = !r1_v || w_adv2;
    assign o_in_ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r1_v <= i_in_valid;
            end
            if (w_adv2) begin
                r2_v <= r1_v;
            end
            if (w_adv3) begin
                r3_v <= r2_v;
            end
            if (w_adv4) begin
                r4_v <= r3_v;
            end
            if (w_adv5) begin
                o_out_valid <= r4_v;
            end
        end
    end

    // stage 1: segment index, offset and both segment ends
    logic [DW-1:0]   w_d;
    logic [SB-1:0]   w_seg;
    logic [IW-1:0]   w_idx0;
    logic [IW-1:0]   w_idx1;
    logic [1:0]      w_sel;

    // x + 8.0 as an unsigned offset from the low end of the grid
    assign w_d    = {~i_x_value[DW-1], i_x_value[DW-2:0]};
    assign w_seg  = w_d[DW-1 -: SB];
    assign w_idx0 = {1'b0, w_seg};
    assign w_idx1 = w_idx0 + IW'(1);

    always_comb begin
        priority case (1'b1)
            r_kind == afbu_pkg::KIND_SIG && r_dir == afbu_pkg::DIR_BWD:
                w_sel = afbu_pkg::TAB_SIG_DER;
            r_kind == afbu_pkg::KIND_SIG:
                w_sel = afbu_pkg::TAB_SIG;
            r_dir == afbu_pkg::DIR_BWD:
                w_sel = afbu_pkg::TAB_GELU_DER;
            default:
                w_sel = afbu_pkg::TAB_GELU;
        endcase
    end

    afbu_pkg::t_tab   r1_t0, r1_t1;
    logic [SH-1:0]    r1_u;
    afbu_pkg::t_data  r1_x, r1_dy;
    logic [1:0]       r1_kind;
    logic             r1_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_t0   <= f_lookup(w_sel, w_idx0);
            r1_t1   <= f_lookup(w_sel, w_idx1);
            r1_u    <= w_d[SH-1:0];
            r1_x    <= i_x_value;
            r1_dy   <= i_grad_in;
            r1_kind <= r_kind;
            r1_dir  <= r_dir;
        end
    end

    // stage 2: slope times offset within the segment
    logic signed [TW:0]   w_diff;
    logic signed [PW-1:0] w_diff_ext;
    logic signed [PW-1:0] w_u_ext;

    assign w_diff     = (TW+1)'(r1_t1) - (TW+1)'(r1_t0);
    assign w_diff_ext = PW'(w_diff);
    assign w_u_ext    = PW'($signed({1'b0, r1_u}));

    logic signed [PW-1:0] r2_prod;
    afbu_pkg::t_tab       r2_t0;
    afbu_pkg::t_data      r2_x, r2_dy;
    logic [1:0]           r2_kind;
    logic                 r2_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_prod <= w_diff_ext * w_u_ext;
            r2_t0   <= r1_t0;
            r2_x    <= r1_x;
            r2_dy   <= r1_dy;
            r2_kind <= r1_kind;
            r2_dir  <= r1_dir;
        end
    end

    // stage 3: add the rounded step to the lower segment end
    logic signed [PW-1:0] w_step_r;
    logic signed [PW-1:0] w_step;
    afbu_pkg::t_tab       w_interp;

    assign w_step_r = r2_prod + PW'(1 << (SH - 1));
    assign w_step   = w_step_r >>> SH;
    assign w_interp = r2_t0 + TW'(w_step);

    afbu_pkg::t_tab   r3_f;
    afbu_pkg::t_data  r3_x, r3_dy;
    logic [1:0]       r3_kind;
    logic             r3_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r3_f    <= w_interp;
            r3_x    <= r2_x;
            r3_dy   <= r2_dy;
            r3_kind <= r2_kind;
            r3_dir  <= r2_dir;
        end
    end

    // stage 4: upstream gradient times derivative
    logic signed [GW-1:0] w_dy_ext;
    logic signed [GW-1:0] w_f_ext;

    assign w_dy_ext = GW'(r3_dy);
    assign w_f_ext  = GW'(r3_f);

    logic signed [GW-1:0] r4_gprod;
    afbu_pkg::t_tab       r4_f;
    afbu_pkg::t_data      r4_x, r4_dy;
    logic [1:0]           r4_kind;
    logic                 r4_dir;

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r4_gprod <= w_dy_ext * w_f_ext;
            r4_f     <= r3_f;
            r4_x     <= r3_x;
            r4_dy    <= r3_dy;
            r4_kind  <= r3_kind;
            r4_dir   <= r3_dir;
        end
    end

    // stage 5: round the gradient, pick the result and saturate
    logic signed [GW:0]   w_gr_r;
    logic signed [GW:0]   w_gr_s;
    logic signed [RW-1:0] w_grad;
    logic signed [RW-1:0] w_pick;
    logic                 w_x_pos;
    afbu_pkg::t_data      w_sat;

    assign w_gr_r  = (GW+1)'(r4_gprod) + (GW+1)'(1 << (FB - 1));
    assign w_gr_s  = w_gr_r >>> FB;
    assign w_grad  = RW'(w_gr_s);
    assign w_x_pos = !r4_x[DW-1] && (r4_x != '0);

    always_comb begin
        unique case (r4_kind)
            afbu_pkg::KIND_RELU: begin
                if (!w_x_pos) begin
                    w_pick = '0;
                end else if (r4_dir == afbu_pkg::DIR_BWD) begin
                    w_pick = RW'(r4_dy);
                end else begin
                    w_pick = RW'(r4_x);
                end
            end
            afbu_pkg::KIND_GELU, afbu_pkg::KIND_SIG: begin
                if (r4_dir == afbu_pkg::DIR_BWD) begin
                    w_pick = w_grad;
                end else begin
                    w_pick = RW'(r4_f);
                end
            end
            afbu_pkg::KIND_UNUSED: w_pick = '0;
            default:               w_pick = '0;
        endcase
    end

    always_comb begin
        if (w_pick > RW'(SAT_HI)) begin
            w_sat = SAT_HI;
        end else if (w_pick < RW'(SAT_LO)) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = DW'(w_pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            o_result <= w_sat;
        end
    end

endmodule
